// ----- rtl/bsaes_pkg.sv -----
// Package with shared types, sizes and the substitution table of the bitsliced AES S-box.
`default_nettype none
package bsaes_pkg;

    localparam int PLANE_W = 64;
    localparam int LANES   = 64;
    localparam int BITS    = 8;

    typedef struct packed {
        logic [PLANE_W-1:0] plane_in7;
        logic [PLANE_W-1:0] plane_in6;
        logic [PLANE_W-1:0] plane_in5;
        logic [PLANE_W-1:0] plane_in4;
        logic [PLANE_W-1:0] plane_in3;
        logic [PLANE_W-1:0] plane_in2;
        logic [PLANE_W-1:0] plane_in1;
        logic [PLANE_W-1:0] plane_in0;
    } sbox_req_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane_out7;
        logic [PLANE_W-1:0] plane_out6;
        logic [PLANE_W-1:0] plane_out5;
        logic [PLANE_W-1:0] plane_out4;
        logic [PLANE_W-1:0] plane_out3;
        logic [PLANE_W-1:0] plane_out2;
        logic [PLANE_W-1:0] plane_out1;
        logic [PLANE_W-1:0] plane_out0;
    } sbox_rsp_t;

    typedef logic [LANES-1:0][BITS-1:0] lane_bytes_t;

    localparam logic [BITS-1:0] SBOX_TABLE [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [BITS-1:0] sbox_lookup(input logic [BITS-1:0] value);
        return SBOX_TABLE[value];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bsaes_lane.sv -----
// One byte lane: gathers its bit from every plane and applies the AES S-box.
`default_nettype none
module bsaes_lane (
    input  wire logic [bsaes_pkg::BITS-1:0] lane_bits,
    output logic      [bsaes_pkg::BITS-1:0] lane_sub
);
    import bsaes_pkg::*;

    always_comb
    begin
        lane_sub = sbox_lookup(lane_bits);
    end

endmodule
`default_nettype wire

// ----- rtl/bsaes_merge.sv -----
// Merging stage: transposes lane bytes back into bit planes and registers the result.
`default_nettype none
module bsaes_merge (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  valid,
    input  wire bsaes_pkg::lane_bytes_t lane_sub,
    output logic                       done,
    output bsaes_pkg::sbox_rsp_t       result
);
    import bsaes_pkg::*;

    logic [BITS-1:0][PLANE_W-1:0] plane_next;
    sbox_rsp_t                    result_reg;
    sbox_rsp_t                    result_next;
    logic                         done_reg;

    // Lanes at or above LANES stay zero in every plane.
    always_comb
    begin
        plane_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            for (int k = 0; k < BITS; k++)
            begin
                plane_next[k][l] = lane_sub[l][k];
            end
        end
        result_next.plane_out0 = plane_next[0];
        result_next.plane_out1 = plane_next[1];
        result_next.plane_out2 = plane_next[2];
        result_next.plane_out3 = plane_next[3];
        result_next.plane_out4 = plane_next[4];
        result_next.plane_out5 = plane_next[5];
        result_next.plane_out6 = plane_next[6];
        result_next.plane_out7 = plane_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ----- rtl/bitsliced_aes_sbox_top.sv -----
// Top level of the bitsliced AES S-box: request register, parallel lanes and merging stage.
//
// A request is taken on every cycle in which start is high; busy never rises, so a new set
// of planes may follow in the very next cycle. Each request yields one result, shown with
// done for exactly one cycle: one register holds the request, the lanes look up their
// bytes in parallel, and the merging stage registers the result planes. Results keep
// request order, and the receiver must take each one in its cycle since it cannot hold
// them off.
`default_nettype none
module bitsliced_aes_sbox_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire bsaes_pkg::sbox_req_t request,
    output logic                      done,
    output bsaes_pkg::sbox_rsp_t      result
);
    import bsaes_pkg::*;

    sbox_req_t   request_reg;
    logic        valid_reg;
    lane_bytes_t lane_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            request_reg <= request;
        end
    end

    assign busy = 1'b0;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        bsaes_lane u_lane (
            .lane_bits ({request_reg.plane_in7[l], request_reg.plane_in6[l],
                         request_reg.plane_in5[l], request_reg.plane_in4[l],
                         request_reg.plane_in3[l], request_reg.plane_in2[l],
                         request_reg.plane_in1[l], request_reg.plane_in0[l]}),
            .lane_sub  (lane_sub[l])
        );
    end

    bsaes_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid_reg),
        .lane_sub (lane_sub),
        .done     (done),
        .result   (result)
    );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for bitsliced_aes_sbox_top with directed and random plane sets.
module testbench;
    import bsaes_pkg::*;

    class sub_bytes_scoreboard;
        logic [BITS-1:0] sub_bytes [256];
        sbox_rsp_t pending_planes [$];
        int errors;

        function new();
            for (int v = 0; v < 256; v++)
            begin
                sub_bytes[v] = affine_map(gf_inverse(v[BITS-1:0]));
            end
            errors = 0;
        endfunction

        function logic [BITS-1:0] gf_mul(logic [BITS-1:0] a, logic [BITS-1:0] b);
            logic [BITS-1:0] prod;
            prod = '0;
            for (int i = 0; i < BITS; i++)
            begin
                if (b[i])
                    prod = prod ^ a;
                a = {a[BITS-2:0], 1'b0} ^ (a[BITS-1] ? 8'h1b : 8'h00);
            end
            return prod;
        endfunction

        // The inverse is a^254 in GF(2^8); zero has no inverse and maps to zero.
        function logic [BITS-1:0] gf_inverse(logic [BITS-1:0] a);
            logic [BITS-1:0] acc;
            acc = 8'h01;
            if (a == '0)
                return '0;
            for (int i = 0; i < 254; i++)
            begin
                acc = gf_mul(acc, a);
            end
            return acc;
        endfunction

        function logic [BITS-1:0] affine_map(logic [BITS-1:0] b);
            return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                     ^ {b[3:0], b[7:4]} ^ 8'h63;
        endfunction

        function void note_request(sbox_req_t req);
            logic [BITS*PLANE_W-1:0] flat_in;
            logic [BITS*PLANE_W-1:0] flat_out;
            logic [BITS-1:0] lane_byte;
            flat_in = req;
            flat_out = '0;
            for (int lane = 0; lane < LANES; lane++)
            begin
                for (int k = 0; k < BITS; k++)
                begin
                    lane_byte[k] = flat_in[k*PLANE_W + lane];
                end
                lane_byte = sub_bytes[lane_byte];
                for (int k = 0; k < BITS; k++)
                begin
                    flat_out[k*PLANE_W + lane] = lane_byte[k];
                end
            end
            pending_planes.push_back(sbox_rsp_t'(flat_out));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(sbox_rsp_t rsp);
            sbox_rsp_t want;
            logic [BITS*PLANE_W-1:0] got_flat;
            logic [BITS*PLANE_W-1:0] want_flat;
            if (pending_planes.size() == 0)
            begin
                report_mismatch("result strobe with no request outstanding");
                return;
            end
            want = pending_planes.pop_front();
            got_flat = rsp;
            want_flat = want;
            for (int k = 0; k < BITS; k++)
            begin
                if (got_flat[k*PLANE_W +: PLANE_W] !== want_flat[k*PLANE_W +: PLANE_W])
                    report_mismatch($sformatf("plane_out%0d got %h expected %h", k,
                        got_flat[k*PLANE_W +: PLANE_W], want_flat[k*PLANE_W +: PLANE_W]));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    sbox_req_t request = '0;
    sbox_rsp_t result;
    bit quiet = 1'b0;
    sub_bytes_scoreboard board;

    bitsliced_aes_sbox_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic sbox_req_t rand_item();
        sbox_req_t item;
        logic [BITS-1:0] fill;
        int style;
        style = $urandom_range(5);
        fill = 8'($urandom_range(255));
        for (int k = 0; k < BITS; k++)
        begin
            case (style)
                3: item[k*PLANE_W +: PLANE_W] = {$urandom, $urandom} & {$urandom, $urandom};
                4: item[k*PLANE_W +: PLANE_W] = {$urandom, $urandom} | {$urandom, $urandom};
                5: item[k*PLANE_W +: PLANE_W] = {PLANE_W{fill[k]}};
                default: item[k*PLANE_W +: PLANE_W] = {$urandom, $urandom};
            endcase
        end
        return item;
    endfunction

    function automatic sbox_req_t planes_from_bytes(lane_bytes_t bytes);
        sbox_req_t item;
        for (int lane = 0; lane < LANES; lane++)
        begin
            for (int k = 0; k < BITS; k++)
            begin
                item[k*PLANE_W + lane] = bytes[lane][k];
            end
        end
        return item;
    endfunction

    task automatic send_planes(input sbox_req_t req);
        while (!quiet && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            request <= rand_item();
            @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_request(request);
            if (done)
                board.check_result(result);
        end
    end

    initial
    begin
        sbox_req_t item;
        lane_bytes_t bytes;
        int settle;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every lane zero, then every lane 0xff.
        send_planes('0);
        send_planes('1);
        // All 256 byte values spread across the lanes.
        for (int blk = 0; blk < 4; blk++)
        begin
            for (int lane = 0; lane < LANES; lane++)
            begin
                bytes[lane] = 8'(blk * LANES + lane);
            end
            send_planes(planes_from_bytes(bytes));
        end
        for (int k = 0; k < BITS; k++)
        begin
            item = '0;
            item[k*PLANE_W +: PLANE_W] = '1;
            send_planes(item);
        end
        send_planes({BITS{64'h5555_5555_5555_5555}});
        send_planes({BITS{64'haaaa_aaaa_aaaa_aaaa}});

        for (int n = 0; n < 1200; n++)
        begin
            quiet = (n >= 500 && n < 800);
            send_planes(rand_item());
        end
        start <= 1'b0;

        settle = 0;
        while (board.pending_planes.size() != 0 && settle < 1000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (4) @(posedge clk);
        if (board.pending_planes.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                board.pending_planes.size()));

        if (board.errors == 0)
            $display("bitsliced_aes_sbox_top verification clean");
        else
            $display("bitsliced_aes_sbox_top verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("bitsliced_aes_sbox_top verification failed");
        $finish;
    end
endmodule

// ----- bitsliced_aes_sbox_top.f -----
rtl/bsaes_pkg.sv
rtl/bsaes_lane.sv
rtl/bsaes_merge.sv
rtl/bitsliced_aes_sbox_top.sv
tb/testbench.sv
